### src/hbcp_pkg.sv
package hbcp_pkg;

    // Payload widths
    localparam int CMD_WIDTH    = 16;
    localparam int PERIOD_WIDTH = 16;
    localparam int GEAR_W       = 16;
    localparam int LIM_W        = 15;
    localparam int FRAC_BITS    = 8;
    localparam int REQ_W        = 2;

    // Datapath widths
    localparam int MAG_W    = CMD_WIDTH + 1;
    localparam int PROD_W   = MAG_W + GEAR_W;
    localparam int SCALED_W = PROD_W - FRAC_BITS;
    localparam int DIVD_W   = LIM_W + PERIOD_WIDTH;
    localparam int DIV_W    = DIVD_W + (DIVD_W % 2);
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int REM_W    = LIM_W + 1;

    // Job queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = (PERIOD_WIDTH > GEAR_W) ? PERIOD_WIDTH : GEAR_W;

    localparam logic [CFG_ADDR_W-1:0] REG_GEAR    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_VEL = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_VEL = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_TRQ = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_REVERSE = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD  = 3'd5;

    localparam logic [GEAR_W-1:0]       GEAR_RST    = GEAR_W'(256);
    localparam logic [LIM_W-1:0]        MAX_VEL_RST = LIM_W'(25600);
    localparam logic [LIM_W-1:0]        MIN_VEL_RST = LIM_W'(0);
    localparam logic [LIM_W-1:0]        MAX_TRQ_RST = LIM_W'(5120);
    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RST  = PERIOD_WIDTH'(999);

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_VEL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TRQ = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EN  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DIS = 2'd3;

    // Stream layout
    localparam int S_TDATA_W  = ((CMD_WIDTH + 7) / 8) * 8;
    localparam int M_FIELDS_W = PERIOD_WIDTH + 2 + 2 * CMD_WIDTH;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 2;
    localparam int M_CW_BIT   = 0;
    localparam int M_DW_BIT   = 1;
    localparam int M_DIR_BIT  = PERIOD_WIDTH;
    localparam int M_RUN_BIT  = PERIOD_WIDTH + 1;

    typedef struct packed {
        logic [GEAR_W-1:0]       gear;
        logic [LIM_W-1:0]        max_vel;
        logic [LIM_W-1:0]        min_vel;
        logic [LIM_W-1:0]        max_trq;
        logic                    rev;
        logic [PERIOD_WIDTH-1:0] period;
    } cfg_t;

    // One classified item, handed from front to back
    typedef struct packed {
        logic                 need_div;
        logic                 use_trq;
        logic [LIM_W-1:0]     mag;
        logic                 cw;
        logic                 dw;
        logic                 dv;
        logic                 running;
        logic [CMD_WIDTH-1:0] vel;
        logic [CMD_WIDTH-1:0] trq;
    } job_t;

endpackage

### src/hbcp_front.sv
module hbcp_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [hbcp_pkg::REQ_W-1:0]      in_req,
    input  logic [hbcp_pkg::CMD_WIDTH-1:0]  in_cmd,
    input  hbcp_pkg::cfg_t                  cfg,
    input  logic                            q_full,
    output logic                            push,
    output hbcp_pkg::job_t                  job
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_CLS  = 2'd2;

    logic [1:0]                          state_reg, state_next;
    logic [hbcp_pkg::REQ_W-1:0]          req_reg;
    logic                                neg_reg;
    logic [hbcp_pkg::MAG_W-1:0]          abs_reg;
    logic [hbcp_pkg::SCALED_W-1:0]       scaled_reg;
    logic                                enabled_reg, enabled_next;
    logic [hbcp_pkg::CMD_WIDTH-1:0]      vel_reg, vel_next;
    logic [hbcp_pkg::CMD_WIDTH-1:0]      trq_reg, trq_next;

    logic [hbcp_pkg::MAG_W-1:0]          cmd_ext;
    logic [hbcp_pkg::PROD_W-1:0]         prod;
    logic [hbcp_pkg::LIM_W-1:0]          lim;
    logic                                over;
    logic                                below;
    logic [hbcp_pkg::LIM_W-1:0]          clamped;
    logic [hbcp_pkg::CMD_WIDTH-1:0]      clamped_ext;
    logic [hbcp_pkg::CMD_WIDTH-1:0]      signed_val;
    logic                                nonzero;
    logic                                dir;

    assign in_ready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_CLS) && !q_full;

    // Sign-extended incoming command, one bit wider so that the magnitude of the most negative value fits
    assign cmd_ext = {in_cmd[hbcp_pkg::CMD_WIDTH-1], in_cmd};

    // Gear scaling
    assign prod = hbcp_pkg::PROD_W'(abs_reg) * hbcp_pkg::PROD_W'(cfg.gear);

    // Clamp against the limit of the mode and compare against the minimum velocity
    assign lim   = (req_reg == hbcp_pkg::REQ_TRQ) ? cfg.max_trq : cfg.max_vel;
    assign over  = scaled_reg > hbcp_pkg::SCALED_W'(lim);
    assign below = !over && (scaled_reg < hbcp_pkg::SCALED_W'(cfg.min_vel));
    assign clamped     = over ? lim : scaled_reg[hbcp_pkg::LIM_W-1:0];
    assign clamped_ext = hbcp_pkg::CMD_WIDTH'(clamped);
    assign signed_val  = neg_reg ? (hbcp_pkg::CMD_WIDTH'(0) - clamped_ext) : clamped_ext;
    assign nonzero     = (clamped != '0);
    assign dir         = (nonzero && !neg_reg) ? !cfg.rev : cfg.rev;

    // Classify the item and compute the next stored state
    always_comb begin
        enabled_next = enabled_reg;
        vel_next     = vel_reg;
        trq_next     = trq_reg;
        job          = '0;
        job.mag      = clamped;
        job.use_trq  = (req_reg == hbcp_pkg::REQ_TRQ);
        unique case (req_reg)
            hbcp_pkg::REQ_EN: begin
                enabled_next = 1'b1;
            end
            hbcp_pkg::REQ_DIS: begin
                enabled_next = 1'b0;
                job.cw       = 1'b1;
            end
            hbcp_pkg::REQ_VEL: begin
                if (enabled_reg) begin
                    job.cw = 1'b1;
                    if (below) begin
                        vel_next = '0;
                    end else begin
                        vel_next     = signed_val;
                        job.dw       = 1'b1;
                        job.dv       = dir;
                        job.need_div = nonzero;
                    end
                end
            end
            hbcp_pkg::REQ_TRQ: begin
                if (enabled_reg) begin
                    trq_next     = signed_val;
                    job.dw       = 1'b1;
                    job.dv       = dir;
                    job.cw       = (cfg.max_trq != '0);
                    job.need_div = nonzero;
                end
            end
        endcase
        job.running = enabled_next;
        job.vel     = vel_next;
        job.trq     = trq_next;
    end

    // Sequence: accept, multiply, classify and push
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (in_valid) state_next = F_MUL;
            F_MUL:   state_next = F_CLS;
            F_CLS:   if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            enabled_reg <= 1'b0;
            vel_reg     <= '0;
            trq_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (push) begin
                enabled_reg <= enabled_next;
                vel_reg     <= vel_next;
                trq_reg     <= trq_next;
            end
        end
    end

    // Hold the item payload
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            req_reg <= in_req;
            neg_reg <= in_cmd[hbcp_pkg::CMD_WIDTH-1];
            abs_reg <= in_cmd[hbcp_pkg::CMD_WIDTH-1] ? (hbcp_pkg::MAG_W'(0) - cmd_ext) : cmd_ext;
        end
        if (state_reg == F_MUL) begin
            scaled_reg <= prod[hbcp_pkg::PROD_W-1:hbcp_pkg::FRAC_BITS];
        end
    end

endmodule

### src/hbcp_queue.sv
module hbcp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  hbcp_pkg::job_t  push_job,
    input  logic            pop,
    output hbcp_pkg::job_t  pop_job,
    output logic            full,
    output logic            empty
);

    hbcp_pkg::job_t                slot_reg [hbcp_pkg::QUEUE_DEPTH];
    logic [hbcp_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [hbcp_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [hbcp_pkg::QCNT_W-1:0]   count_reg;

    assign full    = (count_reg == hbcp_pkg::QCNT_W'(hbcp_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == hbcp_pkg::QPTR_W'(hbcp_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == hbcp_pkg::QPTR_W'(hbcp_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### src/hbcp_back.sv
module hbcp_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  hbcp_pkg::cfg_t                      cfg,
    input  logic                                q_empty,
    input  hbcp_pkg::job_t                      q_job,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hbcp_pkg::M_TDATA_W-1:0]      out_data,
    output logic [hbcp_pkg::M_TUSER_W-1:0]      out_user
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MUL  = 2'd1;
    localparam logic [1:0] B_DIV  = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    logic [1:0]                            state_reg, state_next;
    hbcp_pkg::job_t                        job_reg;
    logic [hbcp_pkg::DIV_W-1:0]            dq_reg;
    logic [hbcp_pkg::REM_W-1:0]            rem_reg;
    logic [hbcp_pkg::DIV_CNT_W-1:0]        cnt_reg;
    logic                                  valid_reg;
    logic [hbcp_pkg::M_TDATA_W-1:0]        data_reg;
    logic [hbcp_pkg::M_TUSER_W-1:0]        user_reg;

    logic [hbcp_pkg::REM_W-1:0]            divisor;
    logic [hbcp_pkg::REM_W-1:0]            t1, r1, t2, r2;
    logic                                  ge1, ge2;
    logic                                  load;
    logic [hbcp_pkg::PERIOD_WIDTH-1:0]     cv;

    assign pop       = (state_reg == B_IDLE) && !q_empty;
    assign load      = (state_reg == B_OUT) && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;

    // Two restoring division steps per cycle
    assign divisor = hbcp_pkg::REM_W'(job_reg.use_trq ? cfg.max_trq : cfg.max_vel);
    assign t1  = {rem_reg[hbcp_pkg::REM_W-2:0], dq_reg[hbcp_pkg::DIV_W-1]};
    assign ge1 = (t1 >= divisor);
    assign r1  = ge1 ? (t1 - divisor) : t1;
    assign t2  = {r1[hbcp_pkg::REM_W-2:0], dq_reg[hbcp_pkg::DIV_W-2]};
    assign ge2 = (t2 >= divisor);
    assign r2  = ge2 ? (t2 - divisor) : t2;

    assign cv = job_reg.need_div ? dq_reg[hbcp_pkg::PERIOD_WIDTH-1:0] : '0;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!q_empty) state_next = q_job.need_div ? B_MUL : B_OUT;
            B_MUL:  state_next = B_DIV;
            B_DIV:  if (cnt_reg == hbcp_pkg::DIV_CNT_W'(hbcp_pkg::DIV_STEPS - 1)) begin
                        state_next = B_OUT;
                    end
            B_OUT:  if (load) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Take the job, form the dividend, iterate the divider
    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= q_job;
        end
        unique case (state_reg)
            B_MUL: begin
                dq_reg  <= hbcp_pkg::DIV_W'(hbcp_pkg::DIVD_W'(job_reg.mag)
                                            * hbcp_pkg::DIVD_W'(cfg.period));
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            B_DIV: begin
                dq_reg  <= {dq_reg[hbcp_pkg::DIV_W-3:0], ge1, ge2};
                rem_reg <= r2;
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= hbcp_pkg::M_TDATA_W'({job_reg.trq, job_reg.vel, job_reg.running,
                                              job_reg.dv, cv});
            user_reg <= {job_reg.dw, job_reg.cw};
        end
    end

endmodule

### src/hbridge_command_to_pwm.sv
// H-bridge command to PWM drive.
// Input stream: s_tuser carries the request kind (velocity, torque, enable,
// disable), s_tdata the signed Q8.8 command. Every accepted transaction gives
// exactly one result transaction on the m_ side: compare and direction values
// with their written flags in m_tuser, plus the running flag and the stored
// velocity and torque commands in m_tdata.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata; the
// user must do so only while the block is idle: the block does not enforce it.
// Unknown addresses are ignored. An item that produces a nonzero compare goes
// through the gear multiply and clamp in the front and the two-bit-per-cycle
// divider in the back; other items skip the divider. The front takes a new
// item only after it has pushed the last one, and the back takes a new job
// only after it has loaded the last result. A two-entry job queue lets the
// front keep accepting while the back divides or while the result waits.
// Reset (aresetn low, synchronous) restores register defaults, disables the
// drive, clears the stored commands and empties the pipeline. A stalled
// receiver holds the result in the output register; the back and then the
// queue and front fill up and s_tready drops.
module hbridge_command_to_pwm (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // command
    input  logic [hbcp_pkg::S_TDATA_W-1:0]         s_tdata,
    // req_type
    input  logic [hbcp_pkg::REQ_W-1:0]             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // compare_value, direction, pwm_running, velocity_cmd, torque_cmd
    output logic [hbcp_pkg::M_TDATA_W-1:0]         m_tdata,
    // compare_written, direction_written
    output logic [hbcp_pkg::M_TUSER_W-1:0]         m_tuser,
    input  logic                                   cfg_we,
    input  logic [hbcp_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [hbcp_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    hbcp_pkg::cfg_t  cfg_reg;
    hbcp_pkg::job_t  push_job;
    hbcp_pkg::job_t  pop_job;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gear    <= hbcp_pkg::GEAR_RST;
            cfg_reg.max_vel <= hbcp_pkg::MAX_VEL_RST;
            cfg_reg.min_vel <= hbcp_pkg::MIN_VEL_RST;
            cfg_reg.max_trq <= hbcp_pkg::MAX_TRQ_RST;
            cfg_reg.rev     <= 1'b0;
            cfg_reg.period  <= hbcp_pkg::PERIOD_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                hbcp_pkg::REG_GEAR:    cfg_reg.gear    <= cfg_wdata[hbcp_pkg::GEAR_W-1:0];
                hbcp_pkg::REG_MAX_VEL: cfg_reg.max_vel <= cfg_wdata[hbcp_pkg::LIM_W-1:0];
                hbcp_pkg::REG_MIN_VEL: cfg_reg.min_vel <= cfg_wdata[hbcp_pkg::LIM_W-1:0];
                hbcp_pkg::REG_MAX_TRQ: cfg_reg.max_trq <= cfg_wdata[hbcp_pkg::LIM_W-1:0];
                hbcp_pkg::REG_REVERSE: cfg_reg.rev     <= cfg_wdata[0];
                hbcp_pkg::REG_PERIOD:  cfg_reg.period  <= cfg_wdata[hbcp_pkg::PERIOD_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    hbcp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_req   (s_tuser),
        .in_cmd   (s_tdata[hbcp_pkg::CMD_WIDTH-1:0]),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (push),
        .job      (push_job)
    );

    hbcp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    hbcp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_job     (pop_job),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

### src/hbcp_checker.sv
module hbcp_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [hbcp_pkg::M_TDATA_W-1:0]      m_tdata,
    input logic [hbcp_pkg::M_TUSER_W-1:0]      m_tuser
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset empties the output
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Unwritten compare reads as zero
    a_cv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[hbcp_pkg::M_CW_BIT]
            |-> m_tdata[hbcp_pkg::PERIOD_WIDTH-1:0] == '0)
        else $error("compare value without write flag");

    // Direction is driven only while running, and reads zero when not driven
    a_dir_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[hbcp_pkg::M_DW_BIT] && m_tdata[hbcp_pkg::M_RUN_BIT])
                     || (!m_tuser[hbcp_pkg::M_DW_BIT] && !m_tdata[hbcp_pkg::M_DIR_BIT]))
        else $error("direction written while disabled or set without write flag");

endmodule

bind hbridge_command_to_pwm hbcp_checker u_hbcp_checker (.*);
